// ----- sv/wlqp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlqp_pkg
// Shared constants, codes and interface types of the weighted lottery
// queue picker.
// ----------------------------------------------------------------------------
package wlqp_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TAG_WIDTH_DEF   = 16;
    localparam int CLASS_COUNT     = 3;

    localparam int WEIGHT_W  = 8;
    localparam int RND_W     = 15;
    localparam int TOTAL_W   = 10;
    localparam int PRIO_W    = 2;
    localparam int QSEL_W    = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_SEL = 1'b1;

    localparam logic [PRIO_W-1:0] PRIO_HIGH = 2'd0;
    localparam logic [PRIO_W-1:0] PRIO_MID  = 2'd1;

    localparam logic [QSEL_W-1:0] Q_HIGH = 2'd0;
    localparam logic [QSEL_W-1:0] Q_MID  = 2'd1;
    localparam logic [QSEL_W-1:0] Q_LOW  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_MID  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_LOW  = 2'd2;

    localparam logic [WEIGHT_W-1:0] WEIGHT_HIGH_RST = 8'd50;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MID_RST  = 8'd30;
    localparam logic [WEIGHT_W-1:0] WEIGHT_LOW_RST  = 8'd20;

    typedef struct packed {
        logic               start;
        logic [RND_W-1:0]   dividend;
        logic [TOTAL_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [TOTAL_W-1:0] remainder;
    } t_div_rsp;

endpackage

// ----- sv/wlqp_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlqp_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module wlqp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 48
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/wlqp_mod.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlqp_mod
// Restoring remainder unit: one dividend bit per cycle through a single
// shift, compare and subtract stage.
// ----------------------------------------------------------------------------
module wlqp_mod (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wlqp_pkg::t_div_req i_req,
    output wlqp_pkg::t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(wlqp_pkg::RND_W);

    logic                           r_busy;
    logic                           r_done;
    logic [CNT_W-1:0]               r_cnt;
    logic [wlqp_pkg::TOTAL_W-1:0]   r_rem;
    logic [wlqp_pkg::RND_W-1:0]     r_dvd;
    logic [wlqp_pkg::TOTAL_W-1:0]   r_dvs;

    logic                           n_busy;
    logic                           n_done;
    logic [CNT_W-1:0]               n_cnt;
    logic [wlqp_pkg::TOTAL_W-1:0]   n_rem;
    logic [wlqp_pkg::RND_W-1:0]     n_dvd;
    logic [wlqp_pkg::TOTAL_W-1:0]   n_dvs;

    logic [wlqp_pkg::TOTAL_W:0]     w_shift;
    logic [wlqp_pkg::TOTAL_W:0]     w_diff;

    assign w_shift = {r_rem, r_dvd[wlqp_pkg::RND_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        n_dvs  = r_dvs;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_dvd  = i_req.dividend;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            if (w_shift >= {1'b0, r_dvs}) begin
                n_rem = w_diff[wlqp_pkg::TOTAL_W-1:0];
            end else begin
                n_rem = w_shift[wlqp_pkg::TOTAL_W-1:0];
            end
            n_dvd = {r_dvd[wlqp_pkg::RND_W-2:0], 1'b0};
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(wlqp_pkg::RND_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.remainder = r_rem;

endmodule

// ----- sv/weighted_lottery_queue_picker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_lottery_queue_picker
// Three FIFO queues of task tags with a weighted lottery select.
// ----------------------------------------------------------------------------
// Every input word yields one result word. An enqueue word passes through
// S_ENQ, which writes the tag unless the queue is full and registers the
// result, and S_DONE, which moves the result into the output register. A
// select word that finds a non-empty queue with tickets goes through the
// ticket sum in S_SETUP, the remainder unit's 15 one-bit steps that reduce
// the random value by the ticket total, the winner, the tag store read, the
// pop, the move into the output register and the return to idle. A select
// with no tickets goes from S_SETUP through S_DONE back to idle. The block
// takes one word at a time and stalls its input while busy; a finished
// result sits in the output register, so the next word can be accepted
// while it waits, and a stalled output adds its stall cycles only when a
// second result is ready behind it. The three queues share one tag store of
// three times QUEUE_DEPTH entries. The user must write weight registers only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module weighted_lottery_queue_picker #(
    parameter int QUEUE_DEPTH = wlqp_pkg::QUEUE_DEPTH_DEF,
    parameter int TAG_WIDTH   = wlqp_pkg::TAG_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_kind,
    input  logic [wlqp_pkg::PRIO_W-1:0]      i_priority_req,
    input  logic [TAG_WIDTH-1:0]             i_task_tag,
    input  logic [wlqp_pkg::RND_W-1:0]       i_random_value,

    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_task_valid,
    output logic [TAG_WIDTH-1:0]             o_picked_tag,
    output logic [wlqp_pkg::QSEL_W-1:0]      o_picked_queue,
    output logic                             o_dropped,

    input  logic                             i_cfg_we,
    input  logic [wlqp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [wlqp_pkg::WEIGHT_W-1:0]    i_cfg_data
);

    localparam int NQ        = wlqp_pkg::CLASS_COUNT;
    localparam int RAM_DEPTH = NQ * QUEUE_DEPTH;
    localparam int AW        = $clog2(RAM_DEPTH);
    localparam int PW        = $clog2(QUEUE_DEPTH);
    localparam int CW        = $clog2(QUEUE_DEPTH + 1);
    localparam int WW        = wlqp_pkg::WEIGHT_W;
    localparam int TW        = wlqp_pkg::TOTAL_W;
    localparam int QW        = wlqp_pkg::QSEL_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENQ,
        S_SETUP,
        S_DIV,
        S_READ,
        S_POP,
        S_DONE
    } t_state;

    t_state                       r_state,  n_state;
    logic [QW-1:0]                r_q,      n_q;
    logic [TAG_WIDTH-1:0]         r_tag,    n_tag;
    logic [wlqp_pkg::RND_W-1:0]   r_rnd,    n_rnd;
    logic [WW-1:0]                r_tick    [NQ];
    logic [WW-1:0]                n_tick    [NQ];
    logic [TW-1:0]                r_total,  n_total;
    logic [PW-1:0]                r_head    [NQ];
    logic [PW-1:0]                n_head    [NQ];
    logic [PW-1:0]                r_tail    [NQ];
    logic [PW-1:0]                n_tail    [NQ];
    logic [CW-1:0]                r_count   [NQ];
    logic [CW-1:0]                n_count   [NQ];
    logic [WW-1:0]                r_weight  [NQ];
    logic [WW-1:0]                n_weight  [NQ];

    logic                         r_res_task_valid, n_res_task_valid;
    logic [TAG_WIDTH-1:0]         r_res_tag,        n_res_tag;
    logic [QW-1:0]                r_res_queue,      n_res_queue;
    logic                         r_res_dropped,    n_res_dropped;

    logic                         r_out_valid,      n_out_valid;
    logic                         r_out_task_valid, n_out_task_valid;
    logic [TAG_WIDTH-1:0]         r_out_tag,        n_out_tag;
    logic [QW-1:0]                r_out_queue,      n_out_queue;
    logic                         r_out_dropped,    n_out_dropped;

    logic [WW-1:0]                w_tick    [NQ];
    logic [TW-1:0]                w_total;
    logic                         w_full;
    logic [PW-1:0]                w_tail_q;
    logic [PW-1:0]                w_head_q;
    logic [AW-1:0]                w_base;
    logic                         w_out_free;

    logic                         w_ram_we;
    logic [AW-1:0]                w_ram_waddr;
    logic                         w_ram_re;
    logic [AW-1:0]                w_ram_raddr;
    logic [TAG_WIDTH-1:0]         w_ram_rdata;

    wlqp_pkg::t_div_req           w_div_req;
    wlqp_pkg::t_div_rsp           w_div_rsp;

    always_comb begin
        for (int k = 0; k < NQ; k++) begin
            w_tick[k] = (r_count[k] != '0) ? r_weight[k] : '0;
        end
    end

    assign w_total    = TW'(w_tick[0]) + TW'(w_tick[1]) + TW'(w_tick[2]);
    assign w_full     = (r_count[r_q] == CW'(QUEUE_DEPTH));
    assign w_tail_q   = r_tail[r_q];
    assign w_head_q   = r_head[r_q];
    assign w_base     = AW'(r_q) * AW'(QUEUE_DEPTH);
    assign w_out_free = !r_out_valid || !i_stall;

    assign w_ram_we    = (r_state == S_ENQ) && !w_full;
    assign w_ram_waddr = w_base + AW'(w_tail_q);
    assign w_ram_re    = (r_state == S_READ);
    assign w_ram_raddr = w_base + AW'(w_head_q);

    assign w_div_req.start    = (r_state == S_SETUP) && (w_total != '0);
    assign w_div_req.dividend = r_rnd;
    assign w_div_req.divisor  = w_total;

    wlqp_ram #(
        .WIDTH (TAG_WIDTH),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (r_tag),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    wlqp_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    always_comb begin
        n_state          = r_state;
        n_q              = r_q;
        n_tag            = r_tag;
        n_rnd            = r_rnd;
        n_tick           = r_tick;
        n_total          = r_total;
        n_head           = r_head;
        n_tail           = r_tail;
        n_count          = r_count;
        n_weight         = r_weight;
        n_res_task_valid = r_res_task_valid;
        n_res_tag        = r_res_tag;
        n_res_queue      = r_res_queue;
        n_res_dropped    = r_res_dropped;
        n_out_valid      = r_out_valid && i_stall;
        n_out_task_valid = r_out_task_valid;
        n_out_tag        = r_out_tag;
        n_out_queue      = r_out_queue;
        n_out_dropped    = r_out_dropped;

        if (i_cfg_we) begin
            case (i_cfg_index)
                wlqp_pkg::REG_WEIGHT_HIGH: n_weight[0] = i_cfg_data;
                wlqp_pkg::REG_WEIGHT_MID:  n_weight[1] = i_cfg_data;
                wlqp_pkg::REG_WEIGHT_LOW:  n_weight[2] = i_cfg_data;
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_tag = i_task_tag;
                    n_rnd = i_random_value;
                    if (i_priority_req == wlqp_pkg::PRIO_HIGH) begin
                        n_q = wlqp_pkg::Q_HIGH;
                    end else if (i_priority_req == wlqp_pkg::PRIO_MID) begin
                        n_q = wlqp_pkg::Q_MID;
                    end else begin
                        n_q = wlqp_pkg::Q_LOW;
                    end
                    n_state = (i_kind == wlqp_pkg::KIND_SEL) ? S_SETUP : S_ENQ;
                end
            end
            S_ENQ: begin
                n_res_task_valid = 1'b0;
                n_res_tag        = '0;
                n_res_queue      = wlqp_pkg::Q_HIGH;
                n_res_dropped    = w_full;
                if (!w_full) begin
                    n_tail[r_q]  = (w_tail_q == PW'(QUEUE_DEPTH - 1)) ?
                                   '0 : w_tail_q + PW'(1);
                    n_count[r_q] = r_count[r_q] + CW'(1);
                end
                n_state = S_DONE;
            end
            S_SETUP: begin
                n_tick  = w_tick;
                n_total = w_total;
                n_res_task_valid = 1'b0;
                n_res_tag        = '0;
                n_res_queue      = wlqp_pkg::Q_HIGH;
                n_res_dropped    = 1'b0;
                n_state = (w_total == '0) ? S_DONE : S_DIV;
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    if (w_div_rsp.remainder < TW'(r_tick[0])) begin
                        n_q = wlqp_pkg::Q_HIGH;
                    end else if (w_div_rsp.remainder <
                                 TW'(r_tick[0]) + TW'(r_tick[1])) begin
                        n_q = wlqp_pkg::Q_MID;
                    end else begin
                        n_q = wlqp_pkg::Q_LOW;
                    end
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_POP;
            end
            S_POP: begin
                n_res_task_valid = 1'b1;
                n_res_tag        = w_ram_rdata;
                n_res_queue      = r_q;
                n_res_dropped    = 1'b0;
                n_head[r_q]      = (w_head_q == PW'(QUEUE_DEPTH - 1)) ?
                                   '0 : w_head_q + PW'(1);
                n_count[r_q]     = r_count[r_q] - CW'(1);
                n_state          = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid      = 1'b1;
                    n_out_task_valid = r_res_task_valid;
                    n_out_tag        = r_res_tag;
                    n_out_queue      = r_res_queue;
                    n_out_dropped    = r_res_dropped;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_weight[0] <= wlqp_pkg::WEIGHT_HIGH_RST;
            r_weight[1] <= wlqp_pkg::WEIGHT_MID_RST;
            r_weight[2] <= wlqp_pkg::WEIGHT_LOW_RST;
            for (int k = 0; k < NQ; k++) begin
                r_head[k]  <= '0;
                r_tail[k]  <= '0;
                r_count[k] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_weight    <= n_weight;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
        end
        r_q              <= n_q;
        r_tag            <= n_tag;
        r_rnd            <= n_rnd;
        r_tick           <= n_tick;
        r_total          <= n_total;
        r_res_task_valid <= n_res_task_valid;
        r_res_tag        <= n_res_tag;
        r_res_queue      <= n_res_queue;
        r_res_dropped    <= n_res_dropped;
        r_out_task_valid <= n_out_task_valid;
        r_out_tag        <= n_out_tag;
        r_out_queue      <= n_out_queue;
        r_out_dropped    <= n_out_dropped;
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_task_valid   = r_out_task_valid;
    assign o_picked_tag   = r_out_tag;
    assign o_picked_queue = r_out_queue;
    assign o_dropped      = r_out_dropped;

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> (r_count[r_q] != '0))
        else $error("pop from an empty queue");

    a_result_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_task_valid && o_dropped))
        else $error("result both picked and dropped");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_div_rsp.done && (r_state == S_DIV)) |-> (w_div_rsp.remainder < r_total))
        else $error("draw not below ticket total");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state != S_IDLE))
        else $error("accepted word not taken up");

endmodule

// ----- sim/weighted_lottery_queue_picker_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_lottery_queue_picker_tb
// Self-checking bench for the three-queue weighted lottery picker.
// ----------------------------------------------------------------------------
// A driver sends enqueue and select words from a pending queue with random
// gaps. An in-bench copy of the three tag queues and the ticket weights works
// out the result of every accepted word. A monitor with random output stalls
// compares each result with the oldest expected one. The run starts with
// directed words (empty select, tag extremes, full queue, zero tickets) and
// then goes through random phases under several weight settings.
// ----------------------------------------------------------------------------
module weighted_lottery_queue_picker_tb;

    localparam int DEPTH      = wlqp_pkg::QUEUE_DEPTH_DEF;
    localparam int TAG_W      = wlqp_pkg::TAG_WIDTH_DEF;
    localparam int NQ         = wlqp_pkg::CLASS_COUNT;
    localparam int PRIO_W     = wlqp_pkg::PRIO_W;
    localparam int RND_W      = wlqp_pkg::RND_W;
    localparam int QSEL_W     = wlqp_pkg::QSEL_W;
    localparam int CFG_IDX_W  = wlqp_pkg::CFG_IDX_W;
    localparam int WEIGHT_W   = wlqp_pkg::WEIGHT_W;
    localparam int IDLE_PCT   = 22;
    localparam int QUIET_MAX  = 2000;
    localparam int TAIL_WAIT  = 40;

    localparam logic [PRIO_W-1:0]    PRIO_LOW   = 2'd2;
    localparam logic [PRIO_W-1:0]    PRIO_SPARE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONE   = 2'd3;

    typedef struct packed {
        logic               kind;
        logic [PRIO_W-1:0]  prio;
        logic [TAG_W-1:0]   tag;
        logic [RND_W-1:0]   rnd;
    } t_sched_word;

    typedef struct packed {
        logic               task_valid;
        logic [TAG_W-1:0]   tag;
        logic [QSEL_W-1:0]  queue;
        logic               dropped;
    } t_pick;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                 in_valid   = 1'b0;
    logic                 in_kind    = wlqp_pkg::KIND_ENQ;
    logic [PRIO_W-1:0]    in_prio    = wlqp_pkg::PRIO_HIGH;
    logic [TAG_W-1:0]     in_tag     = '0;
    logic [RND_W-1:0]     in_rnd     = '0;
    logic                 out_stall  = 1'b0;
    logic                 cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index  = wlqp_pkg::REG_WEIGHT_HIGH;
    logic [WEIGHT_W-1:0]  cfg_data   = '0;

    logic                 o_stall;
    logic                 o_valid;
    logic                 o_task_valid;
    logic [TAG_W-1:0]     o_picked_tag;
    logic [QSEL_W-1:0]    o_picked_queue;
    logic                 o_dropped;

    t_sched_word pending_words[$];
    t_pick       expected_picks[$];

    logic [TAG_W-1:0]    tag_mem [NQ][DEPTH];
    int                  head_slot [NQ];
    int                  tail_slot [NQ];
    int                  fill [NQ];
    logic [WEIGHT_W-1:0] ticket_weight [NQ];

    bit steady = 1'b0;
    int mismatch_count = 0;
    int quiet_cycles = 0;

    weighted_lottery_queue_picker dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (in_valid),
        .o_stall        (o_stall),
        .i_kind         (in_kind),
        .i_priority_req (in_prio),
        .i_task_tag     (in_tag),
        .i_random_value (in_rnd),
        .o_valid        (o_valid),
        .i_stall        (out_stall),
        .o_task_valid   (o_task_valid),
        .o_picked_tag   (o_picked_tag),
        .o_picked_queue (o_picked_queue),
        .o_dropped      (o_dropped),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always #2 i_clk = ~i_clk;

    task automatic note_mismatch(input string what, input int got, input int want);
        $display("[%0t] pick check failed: %s got 0x%0h want 0x%0h", $realtime, what, got,
                 want);
        mismatch_count++;
    endtask

    task automatic predict_pick(input t_sched_word w);
        t_pick             p;
        logic [QSEL_W-1:0] q;
        int                tick [NQ];
        int                total;
        int                draw;
        p = '0;
        if (w.kind == wlqp_pkg::KIND_ENQ) begin
            q = (w.prio == wlqp_pkg::PRIO_HIGH) ? wlqp_pkg::Q_HIGH :
                (w.prio == wlqp_pkg::PRIO_MID) ? wlqp_pkg::Q_MID : wlqp_pkg::Q_LOW;
            if (fill[q] >= DEPTH) begin
                p.dropped = 1'b1;
            end else begin
                tag_mem[q][tail_slot[q]] = w.tag;
                tail_slot[q] = (tail_slot[q] + 1) % DEPTH;
                fill[q]++;
            end
        end else begin
            total = 0;
            for (int i = 0; i < NQ; i++) begin
                tick[i] = (fill[i] != 0) ? int'(ticket_weight[i]) : 0;
                total += tick[i];
            end
            if (total != 0) begin
                draw = int'(w.rnd) % total;
                if (draw < tick[wlqp_pkg::Q_HIGH]) begin
                    q = wlqp_pkg::Q_HIGH;
                end else if (draw < tick[wlqp_pkg::Q_HIGH] + tick[wlqp_pkg::Q_MID]) begin
                    q = wlqp_pkg::Q_MID;
                end else begin
                    q = wlqp_pkg::Q_LOW;
                end
                p.task_valid = 1'b1;
                p.tag = tag_mem[q][head_slot[q]];
                p.queue = q;
                head_slot[q] = (head_slot[q] + 1) % DEPTH;
                fill[q]--;
            end
        end
        expected_picks.push_back(p);
    endtask

    // Driver: hold a stalled word, advance on acceptance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_stall) begin
                predict_pick('{in_kind, in_prio, in_tag, in_rnd});
            end
            if (!in_valid || !o_stall) begin
                if (pending_words.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                    in_valid <= 1'b1;
                    in_kind  <= pending_words[0].kind;
                    in_prio  <= pending_words[0].prio;
                    in_tag   <= pending_words[0].tag;
                    in_rnd   <= pending_words[0].rnd;
                    void'(pending_words.pop_front());
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        t_pick want;
        if (i_rst_n) begin
            if (o_valid && !out_stall) begin
                if (expected_picks.size() == 0) begin
                    note_mismatch("unexpected word, tag", int'(o_picked_tag), 0);
                end else begin
                    want = expected_picks.pop_front();
                    if (o_task_valid !== want.task_valid)
                        note_mismatch("task_valid", int'(o_task_valid),
                                      int'(want.task_valid));
                    if (o_picked_tag !== want.tag)
                        note_mismatch("picked_tag", int'(o_picked_tag), int'(want.tag));
                    if (o_picked_queue !== want.queue)
                        note_mismatch("picked_queue", int'(o_picked_queue),
                                      int'(want.queue));
                    if (o_dropped !== want.dropped)
                        note_mismatch("dropped", int'(o_dropped), int'(want.dropped));
                end
            end
            out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !o_stall) || (o_valid && !out_stall) || cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_MAX) begin
                $display("weighted_lottery_queue_picker: mismatch");
                $finish;
            end
        end
    end

    task automatic add_word(input logic kind, input logic [PRIO_W-1:0] prio,
                            input logic [TAG_W-1:0] tag, input logic [RND_W-1:0] rnd);
        pending_words.push_back('{kind, prio, tag, rnd});
    endtask

    task automatic write_weight(input logic [CFG_IDX_W-1:0] idx,
                                input logic [WEIGHT_W-1:0] val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx != REG_NONE)
            ticket_weight[idx] = val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_weights(input int wh, input int wm, input int wl);
        write_weight(wlqp_pkg::REG_WEIGHT_HIGH, wh[WEIGHT_W-1:0]);
        write_weight(wlqp_pkg::REG_WEIGHT_MID, wm[WEIGHT_W-1:0]);
        write_weight(wlqp_pkg::REG_WEIGHT_LOW, wl[WEIGHT_W-1:0]);
    endtask

    task automatic wait_drained();
        while (pending_words.size() > 0 || in_valid || expected_picks.size() > 0)
            @(posedge i_clk);
    endtask

    // Alternate filling and draining bursts so queues hit both full and empty.
    task automatic run_random(input int n);
        int               enq_pct;
        logic [RND_W-1:0] rnd;
        enq_pct = 78;
        for (int k = 0; k < n; k++) begin
            if (k % 48 == 0)
                enq_pct = (enq_pct == 78) ? 28 : 78;
            case ($urandom_range(15))
                0:       rnd = '0;
                1:       rnd = '1;
                default: rnd = RND_W'($urandom_range(32767));
            endcase
            add_word(($urandom_range(99) < enq_pct) ? wlqp_pkg::KIND_ENQ : wlqp_pkg::KIND_SEL,
                     PRIO_W'($urandom_range(3)), TAG_W'($urandom_range(65535)), rnd);
        end
        wait_drained();
    endtask

    initial begin
        for (int i = 0; i < NQ; i++) begin
            head_slot[i] = 0;
            tail_slot[i] = 0;
            fill[i] = 0;
        end
        ticket_weight[wlqp_pkg::Q_HIGH] = wlqp_pkg::WEIGHT_HIGH_RST;
        ticket_weight[wlqp_pkg::Q_MID]  = wlqp_pkg::WEIGHT_MID_RST;
        ticket_weight[wlqp_pkg::Q_LOW]  = wlqp_pkg::WEIGHT_LOW_RST;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_word(wlqp_pkg::KIND_SEL, PRIO_SPARE, 16'hFFFF, 15'h7FFF);
        add_word(wlqp_pkg::KIND_ENQ, wlqp_pkg::PRIO_HIGH, 16'h0000, 15'h7FFF);
        add_word(wlqp_pkg::KIND_ENQ, wlqp_pkg::PRIO_MID, 16'hFFFF, 15'h0000);
        for (int i = 0; i < DEPTH; i++)
            add_word(wlqp_pkg::KIND_ENQ, (i % 2) ? PRIO_SPARE : PRIO_LOW,
                     TAG_W'((i % 2) ? (32'hAAAA ^ i) : (32'h5555 ^ i)),
                     RND_W'($urandom_range(32767)));
        add_word(wlqp_pkg::KIND_ENQ, PRIO_SPARE, 16'hFFFF, 15'h0000);
        add_word(wlqp_pkg::KIND_SEL, wlqp_pkg::PRIO_HIGH, 16'h0000, 15'h0000);
        add_word(wlqp_pkg::KIND_SEL, wlqp_pkg::PRIO_MID, 16'h1234, 15'h7FFF);
        add_word(wlqp_pkg::KIND_SEL, PRIO_LOW, 16'hFFFF, 15'd99);
        add_word(wlqp_pkg::KIND_SEL, wlqp_pkg::PRIO_HIGH, 16'h0000, 15'd49);
        wait_drained();

        // Zero tickets with a non-empty queue.
        set_weights(0, 0, 0);
        add_word(wlqp_pkg::KIND_ENQ, wlqp_pkg::PRIO_HIGH, 16'h1234, 15'h0000);
        add_word(wlqp_pkg::KIND_SEL, wlqp_pkg::PRIO_HIGH, 16'h0000, 15'd12345);
        add_word(wlqp_pkg::KIND_SEL, PRIO_LOW, 16'hFFFF, 15'h7FFF);
        wait_drained();

        set_weights(255, 255, 255);
        steady = 1'b1;
        run_random(230);
        steady = 1'b0;

        set_weights(0, 255, 1);
        run_random(230);

        write_weight(REG_NONE, WEIGHT_W'($urandom_range(255)));
        set_weights(1, 0, 0);
        run_random(200);

        set_weights(int'(wlqp_pkg::WEIGHT_HIGH_RST), int'(wlqp_pkg::WEIGHT_MID_RST),
                    int'(wlqp_pkg::WEIGHT_LOW_RST));
        run_random(230);

        for (int p = 0; p < 2; p++) begin
            set_weights(int'($urandom_range(255)), int'($urandom_range(255)),
                        int'($urandom_range(255)));
            run_random(240);
        end

        repeat (TAIL_WAIT) @(posedge i_clk);
        if (mismatch_count == 0 && expected_picks.size() == 0) begin
            $display("weighted_lottery_queue_picker: match");
        end else begin
            $display("weighted_lottery_queue_picker: mismatch");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/wlqp_pkg.sv
sv/wlqp_ram.sv
sv/wlqp_mod.sv
sv/weighted_lottery_queue_picker.sv
sim/weighted_lottery_queue_picker_tb.sv
